// File: hw/rtl/hpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_pkg: shared types and constants for the binary16 adder
// Field masks and the channel payload widths.
// ----------------------------------------------------------------------------
package hpa_pkg;

  localparam int unsigned HalfW = 16;

  localparam logic [15:0] SIGN_MASK  = 16'h8000;
  localparam logic [15:0] EXP_MASK   = 16'h7c00;
  localparam logic [15:0] MANT_MASK  = 16'h03ff;
  localparam logic [15:0] HIDDEN_BIT = 16'h0400;
  localparam logic [15:0] TOP_BIT    = 16'h4000;
  localparam logic [15:0] ODD_MSB    = 16'h2000;
  localparam logic [15:0] GRS_MASK   = 16'h0007;

  typedef logic [HalfW-1:0] half_t;

  // Leading zeros of a 16-bit value (16 when zero).
  function automatic logic [4:0] lzc16(input logic [15:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd16;
    found = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(15 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// File: hw/rtl/hpa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_in_if: operand channel
// Valid/ready channel carrying one pair of binary16 operands.
// ----------------------------------------------------------------------------
interface hpa_in_if import hpa_pkg::*; ();
  logic  valid;
  logic  ready;
  half_t operand_a;
  half_t operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

// File: hw/rtl/hpa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_out_if: result channel
// Valid/ready channel carrying one binary16 sum.
// ----------------------------------------------------------------------------
interface hpa_out_if import hpa_pkg::*; ();
  logic  valid;
  logic  ready;
  half_t sum_bits;

  modport source (output valid, output sum_bits, input ready);
  modport sink   (input valid, input sum_bits, output ready);
endinterface

// File: hw/rtl/half_precision_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_precision_adder: binary16 adder
// Pipeline: operands are captured in the input regs on accept and the sum in
// the result regs, with the add datapath as one stage between the regs.
// Throughput: one item per cycle while the receiver is ready to take results.
// Reset: synchronous active-low rst_n clears both valid flags; no other state.
// Stall: each stage holds while the downstream stage is full and not drained.
// ----------------------------------------------------------------------------
module half_precision_adder
  import hpa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  hpa_in_if.sink       in_ch,
  hpa_out_if.source    out_ch
);

  logic  in_vld_r;
  half_t x_r, y_r;
  logic  out_vld_r;
  half_t sum_r;
  half_t res_nxt;
  logic  stg_adv;
  logic  in_take;

  assign stg_adv     = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !in_vld_r || stg_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_vld_r <= in_ch.valid;
      if (stg_adv) out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r <= in_ch.operand_a;
      y_r <= in_ch.operand_b;
    end
    if (stg_adv && in_vld_r) sum_r <= res_nxt;
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.sum_bits = sum_r;

  // Add datapath
  always_comb begin
    logic        swap, a_inf, dsign, a_bigger, exact0;
    logic [15:0] as, bs, xm, ym, am0, bm0;
    logic [4:0]  xe, ye, ea, eb, sa5, nsa;
    logic [15:0] amh, bmh, a_m, b_full, shifted, smask, b_m, mag, zs, dm, zm, r;
    logic [16:0] sum;
    logic [5:0]  de, ce;
    logic [4:0]  lz;
    logic [15:0] ex16;
    swap  = y_r[14:10] > x_r[14:10];
    xe    = x_r[14:10];
    ye    = y_r[14:10];
    xm    = x_r & MANT_MASK;
    ym    = y_r & MANT_MASK;
    as    = (swap ? y_r : x_r) & SIGN_MASK;
    bs    = (swap ? x_r : y_r) & SIGN_MASK;
    ea    = swap ? ye : xe;
    eb    = swap ? xe : ye;
    am0   = swap ? ym : xm;
    bm0   = swap ? xm : ym;
    a_inf = ({1'b0, ea, 10'd0} | am0) == EXP_MASK;
    amh   = am0 | ((ea != 5'd0) ? HIDDEN_BIT : 16'd0);
    bmh   = bm0 | ((eb != 5'd0) ? HIDDEN_BIT : 16'd0);
    // ea >= eb always, so the shift fits in 5 bits
    sa5   = (eb == 5'd0 && ea != 5'd0) ? ea - 5'd1 : ea - eb;
    a_m   = amh << 3;
    b_full = bmh << 3;
    shifted = b_full >> sa5;
    smask = (sa5 >= 5'd16) ? 16'hffff : ((16'd1 << sa5) - 16'd1);
    b_m   = shifted | {15'd0, (b_full & smask) != 16'd0};
    dsign = as != bs;
    sum   = {1'b0, a_m} + {1'b0, b_m};
    a_bigger = a_m > b_m;
    mag   = a_bigger ? a_m - b_m : b_m - a_m;
    zs    = dsign ? (a_bigger ? as : bs) : as;
    lz    = lzc16(mag);
    // mag < 2^15 so lz >= 1
    nsa   = lz - 5'd1;
    if (ea != 5'd0) begin
      if (ea < nsa) begin
        dm = mag << (ea - 5'd1);
        de = 6'd0;
      end else begin
        dm = mag << nsa;
        de = {1'b0, ea - nsa};
      end
    end else begin
      dm = mag;
      de = 6'd0;
    end
    exact0 = dsign && dm == 16'd0;
    zm = dsign ? dm : sum[15:0];
    ce = dsign ? de : {1'b0, ea};
    if ((zm & TOP_BIT) != 16'd0) begin
      zm = zm >> 1;
      ce = ce + 6'd1;
    end
    if (ea == 5'd0 && (zm & ODD_MSB) != 16'd0) ce = ce + 6'd1;
    zm = zm + (zm & GRS_MASK);
    if ((zm & TOP_BIT) != 16'd0) ce = ce + 6'd1;
    ex16 = {ce, 10'd0};
    r = zs | ex16 | ((zm >> 3) & MANT_MASK);
    if (a_inf) r = as | EXP_MASK;
    if (exact0) r = 16'd0;
    res_nxt = r;
  end

  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(sum_r))
    else $error("result changed under stall");
  ap_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && stg_adv |=> out_vld_r)
    else $error("item lost between stages");
  ap_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ch.ready)
    else $error("empty input stage not ready");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: binary16 adder testbench
// Drives operand pairs with random idling and stalls, predicts each sum
// bit for bit and checks results in order against the predicted sums.
// ----------------------------------------------------------------------------
module tb_top
  import hpa_pkg::*;
;

  localparam int unsigned WatchdogLimit = 2000;

  class sum_scoreboard;
    half_t pending_sums[$];
    int    mismatches;
    int    checked;

    function half_t predict_sum(half_t x, half_t y);
      logic [31:0] xs, xe, xm, ys, ye, ym, as_, ae, am0, bs, be, bm0;
      logic [31:0] ea, eb, amh, bmh, sa, a_m, b_full, shifted, smask, b_m;
      logic [31:0] sum, mag, zs, nsa, dm, de, zm, ce, mant, r, lz;
      logic        swap, a_inf, dsign, a_bigger, exact0;
      xs = x & SIGN_MASK; xe = x & EXP_MASK; xm = x & MANT_MASK;
      ys = y & SIGN_MASK; ye = y & EXP_MASK; ym = y & MANT_MASK;
      swap = ye > xe;
      as_ = swap ? ys : xs; ae = swap ? ye : xe; am0 = swap ? ym : xm;
      bs = swap ? xs : ys; be = swap ? xe : ye; bm0 = swap ? xm : ym;
      a_inf = (ae | am0) == 32'(EXP_MASK);
      ea = ae >> 10; eb = be >> 10;
      amh = am0 | (ea != 0 ? 32'(HIDDEN_BIT) : 0);
      bmh = bm0 | (eb != 0 ? 32'(HIDDEN_BIT) : 0);
      sa = (eb == 0 && ea != 0) ? ea - 1 : ea - eb;
      a_m = amh << 3;
      b_full = bmh << 3;
      shifted = (sa < 32) ? b_full >> sa : 0;
      smask = (sa >= 16) ? 32'hffff : (32'd1 << sa) - 1;
      b_m = shifted | ((b_full & smask) != 0 ? 1 : 0);
      dsign = (as_ ^ bs) != 0;
      sum = a_m + b_m;
      a_bigger = a_m > b_m;
      mag = a_bigger ? a_m - b_m : b_m - a_m;
      zs = dsign ? (a_bigger ? as_ : bs) : as_;
      lz = 16;
      for (int i = 0; i < 16; i++)
        if (mag[15 - i] && lz == 16) lz = i;
      nsa = lz - 1;
      if (ea != 0) begin
        if (ea < nsa) begin
          dm = (mag << (ea - 1)) & 32'hffff;
          de = 0;
        end else begin
          dm = (mag << nsa) & 32'hffff;
          de = ea - nsa;
        end
      end else begin
        dm = mag;
        de = 0;
      end
      exact0 = dsign && dm == 0;
      zm = dsign ? dm : sum;
      ce = dsign ? de : ea;
      if ((zm & TOP_BIT) != 0) begin
        zm = zm >> 1;
        ce = ce + 1;
      end
      if (ae == 0 && (zm & ODD_MSB) != 0) ce = ce + 1;
      zm = (zm + (zm & GRS_MASK)) & 32'hffff;
      if ((zm & TOP_BIT) != 0) ce = ce + 1;
      mant = (zm >> 3) & MANT_MASK;
      r = (zs | ((ce << 10) & 32'hffff) | mant) & 32'hffff;
      if (a_inf) r = as_ | EXP_MASK;
      if (exact0) r = 0;
      return r[15:0];
    endfunction

    function void note_operands(half_t a, half_t b);
      pending_sums.push_back(predict_sum(a, b));
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_sum(half_t got);
      half_t want;
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected sum %h", got));
        return;
      end
      want = pending_sums.pop_front();
      checked++;
      if (got !== want)
        report_mismatch($sformatf("sum_bits got %h want %h", got, want));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   idle_cycles;
  int   sent;

  hpa_in_if  in_ch ();
  hpa_out_if out_ch ();
  sum_scoreboard sb;

  half_precision_adder uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels and run the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_operands(in_ch.operand_a, in_ch.operand_b);
      if (out_ch.valid && out_ch.ready) sb.check_sum(out_ch.sum_bits);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver stall, changed at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Called at a falling edge; leaves valid high so items can go back to back.
  task send_pair(half_t a, half_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task drain;
    in_ch.valid <= 1'b0;
    while (sb.pending_sums.size() != 0) @(negedge clk);
  endtask

  function automatic half_t rand_half();
    half_t h;
    int    k;
    h = half_t'($urandom());
    k = $urandom_range(9);
    // bias toward zeros, denormals, infinities and NaNs
    if (k == 0) h[14:10] = 5'd0;
    else if (k == 1) h[14:10] = 5'd31;
    else if (k == 2) h[9:0] = 10'd0;
    else if (k == 3) h[14:10] = 5'd30;
    return h;
  endfunction

  task random_phase(int n, int idle_pct, int stall_pct);
    half_t a;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      a = rand_half();
      // near cancellation a quarter of the time
      if ($urandom_range(3) == 0) send_pair(a, a ^ 16'h8000 ^ 16'($urandom_range(3)));
      else send_pair(a, rand_half());
    end
  endtask

  initial begin
    half_t dir_a[$];
    half_t dir_b[$];
    sb = new();
    rst_n = 1'b0;
    idle_cycles = 0;
    sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zeros, infinities, inf minus inf, NaN, denormals, max sum carry, cancel
    dir_a = '{16'h0000, 16'h8000, 16'h7c00, 16'h7c00, 16'h7e00, 16'h0001,
              16'h03ff, 16'h7bff, 16'h3c00, 16'h3c00, 16'hffff, 16'h0400,
              16'h7bff, 16'h3c01, 16'h0000, 16'hfc00, 16'h5555, 16'h0f0f};
    dir_b = '{16'h0000, 16'h0000, 16'h3c00, 16'hfc00, 16'h3c00, 16'h0001,
              16'h0001, 16'h7bff, 16'hbc00, 16'h0001, 16'hffff, 16'h8001,
              16'h4000, 16'hbc00, 16'h83ff, 16'h7c00, 16'h3333, 16'h001f};
    foreach (dir_a[i]) send_pair(dir_a[i], dir_b[i]);
    drain();

    random_phase(150, 0, 0);
    random_phase(150, 66, 0);
    drain();
    random_phase(150, 0, 66);
    random_phase(150, 32, 32);
    drain();
    recv_stall_pct = 0;
    repeat (10) @(negedge clk);

    $display("sent %0d operand pairs, checked %0d sums across idle and stall phases",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending_sums.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
